// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port-level checker (mhe_checker).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("assertion failed");

`endif

// ===== rtl/mhe_pkg.sv =====
// ----------------------------------------------------------------------------
// mhe_pkg
// Constants, helper functions and controller/datapath types for the hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhe_pkg;

	localparam logic [63:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MUL_LO    = HASH_MUL[31:0];
	localparam logic [31:0] MUL_HI    = HASH_MUL[63:32];
	localparam int unsigned MIX_SHIFT = 47;
	localparam logic [2:0]  TAIL_MASK = 3'h7;
	localparam logic [1:0]  MUL_STEP_LAST = 2'd2;

	function automatic logic [63:0] shiftmix(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

	// keep the low tail_cnt bytes of a word
	function automatic logic [63:0] tail_keep(input logic [2:0] tail_cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) < tail_cnt) begin
				m[8*i +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	typedef enum logic [2:0] {
		MS_LEN,
		MS_WORD,
		MS_KMIX,
		MS_HXK,
		MS_HTAIL,
		MS_FIN_H,
		MS_FIN_P
	} mul_sel_t;

	typedef enum logic [1:0] {
		H_KEEP,
		H_INIT,
		H_PROD
	} h_sel_t;

	typedef struct packed {
		logic     ld_in;
		logic     mul_start;
		mul_sel_t mul_sel;
		h_sel_t   h_sel;
		logic     res_ld;
		logic     out_ld;
	} ctrl_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic empty;
		logic tail_nz;
		logic mul_done;
		logic out_free;
	} dp_status_t;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DISPATCH = 9'b000000010,
		ST_INIT     = 9'b000000100,
		ST_BODY     = 9'b000001000,
		ST_K1       = 9'b000010000,
		ST_K2       = 9'b000100000,
		ST_HMUL     = 9'b001000000,
		ST_FIN      = 9'b010000000,
		ST_STORE    = 9'b100000000
	} state_t;

endpackage

// ===== rtl/mhe_mul.sv =====
// ----------------------------------------------------------------------------
// mhe_mul
// Low 64 bits of a * HASH_MUL, three passes through one 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhe_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] product
);

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	// lo*lo, lo*hi, hi*lo; the cross terms only feed the upper half
	assign mul_a = (step_q == mhe_pkg::MUL_STEP_LAST) ? a_q[63:32] : a_q[31:0];
	assign mul_b = (step_q == 2'd1) ? mhe_pkg::MUL_HI : mhe_pkg::MUL_LO;
	assign prod  = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == mhe_pkg::MUL_STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'h0};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/mhe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhe_ctrl
// Sequencer: walks each transaction through the init, mix, tail and finalise steps that apply to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mhe_pkg::dp_status_t st,
	output mhe_pkg::ctrl_cmd_t  cmd
);

	mhe_pkg::state_t state_q;
	mhe_pkg::state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd.ld_in     = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mul_sel   = mhe_pkg::MS_LEN;
		cmd.h_sel     = mhe_pkg::H_KEEP;
		cmd.res_ld    = 1'b0;
		cmd.out_ld    = 1'b0;
		unique case (state_q)
			mhe_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = mhe_pkg::ST_DISPATCH;
				end
			end
			mhe_pkg::ST_DISPATCH: begin
				if (st.first) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mhe_pkg::MS_LEN;
					state_d       = mhe_pkg::ST_INIT;
				end else begin
					state_d = mhe_pkg::ST_BODY;
				end
			end
			mhe_pkg::ST_INIT: begin
				if (st.mul_done) begin
					cmd.h_sel = mhe_pkg::H_INIT;
					state_d   = mhe_pkg::ST_BODY;
				end
			end
			mhe_pkg::ST_BODY: begin
				priority if (st.empty) begin
					if (st.last) begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = mhe_pkg::MS_FIN_H;
						state_d       = mhe_pkg::ST_FIN;
					end else begin
						state_d = mhe_pkg::ST_IDLE;
					end
				end else if (st.last && st.tail_nz) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mhe_pkg::MS_HTAIL;
					state_d       = mhe_pkg::ST_HMUL;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mhe_pkg::MS_WORD;
					state_d       = mhe_pkg::ST_K1;
				end
			end
			mhe_pkg::ST_K1: begin
				if (st.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mhe_pkg::MS_KMIX;
					state_d       = mhe_pkg::ST_K2;
				end
			end
			mhe_pkg::ST_K2: begin
				if (st.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mhe_pkg::MS_HXK;
					state_d       = mhe_pkg::ST_HMUL;
				end
			end
			mhe_pkg::ST_HMUL: begin
				if (st.mul_done) begin
					cmd.h_sel = mhe_pkg::H_PROD;
					if (st.last) begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = mhe_pkg::MS_FIN_P;
						state_d       = mhe_pkg::ST_FIN;
					end else begin
						state_d = mhe_pkg::ST_IDLE;
					end
				end
			end
			mhe_pkg::ST_FIN: begin
				if (st.mul_done) begin
					cmd.res_ld = 1'b1;
					state_d    = mhe_pkg::ST_STORE;
				end
			end
			mhe_pkg::ST_STORE: begin
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = mhe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mhe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == mhe_pkg::ST_IDLE);

endmodule

// ===== rtl/mhe_dp.sv =====
// ----------------------------------------------------------------------------
// mhe_dp
// Hash datapath: input latch, running hash, operand select and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seed_we,
	input  logic [63:0]         seed_wdata,
	input  logic [63:0]         data_word,
	input  logic [47:0]         message_length,
	input  logic                first_word,
	input  logic                last_word,
	input  mhe_pkg::ctrl_cmd_t  cmd,
	output mhe_pkg::dp_status_t st,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         hash_value
);

	logic [63:0] seed_q;
	logic [63:0] word_q;
	logic [47:0] len_q;
	logic        first_q;
	logic        last_q;
	logic [2:0]  tail_q;
	logic        empty_q;
	logic [63:0] h_q;
	logic [63:0] res_q;
	logic [63:0] out_q;
	logic        out_valid_q;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] prod;

	mhe_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.done    (mul_done),
		.product (prod)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			mhe_pkg::MS_LEN:   mul_a = {16'h0, len_q};
			mhe_pkg::MS_WORD:  mul_a = word_q;
			mhe_pkg::MS_KMIX:  mul_a = mhe_pkg::shiftmix(prod);
			mhe_pkg::MS_HXK:   mul_a = h_q ^ prod;
			mhe_pkg::MS_HTAIL: mul_a = h_q ^ (word_q & mhe_pkg::tail_keep(tail_q));
			mhe_pkg::MS_FIN_H: mul_a = mhe_pkg::shiftmix(h_q);
			mhe_pkg::MS_FIN_P: mul_a = mhe_pkg::shiftmix(prod);
			default:           mul_a = word_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			h_q         <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (cmd.ld_in) begin
				first_q <= first_word;
				last_q  <= last_word;
				if (first_word) begin
					tail_q  <= message_length[2:0] & mhe_pkg::TAIL_MASK;
					empty_q <= (message_length == '0);
				end
			end
			unique case (cmd.h_sel)
				mhe_pkg::H_INIT: h_q <= seed_q ^ prod;
				mhe_pkg::H_PROD: h_q <= prod;
				default:         h_q <= h_q;
			endcase
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			word_q <= data_word;
			len_q  <= message_length;
		end
		if (cmd.res_ld) begin
			res_q <= mhe_pkg::shiftmix(prod);
		end
		if (cmd.out_ld) begin
			out_q <= res_q;
		end
	end

	assign st.first    = first_q;
	assign st.last     = last_q;
	assign st.empty    = empty_q;
	assign st.tail_nz  = (tail_q != 3'd0);
	assign st.mul_done = mul_done;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

endmodule

// ===== rtl/murmur64_hash_engine.sv =====
// ----------------------------------------------------------------------------
// murmur64_hash_engine: seeded 64-bit Murmur hash; one transaction at a time.
// A first word adds the length multiply and a last word adds the finalise steps;
// all products come from one shared 32x32 multiplier.
// Async reset clears seed, running hash, tail count and empty flag to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module murmur64_hash_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [63:0]   cfg_wr_data,   // seed
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,       // [63:0] data_word, [111:64] message_length
	input  logic          s_tuser,       // [0] first_word
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata        // [63:0] hash_value
);

	mhe_pkg::ctrl_cmd_t  cmd;
	mhe_pkg::dp_status_t st;

	mhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mhe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.seed_we        (cfg_wr_en),
		.seed_wdata     (cfg_wr_data),
		.data_word      (s_tdata[63:0]),
		.message_length (s_tdata[111:64]),
		.first_word     (s_tuser),
		.last_word      (s_tlast),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.hash_value     (m_tdata)
	);

endmodule

// ===== rtl/mhe_checker.sv =====
// ----------------------------------------------------------------------------
// mhe_checker
// Port-level checks on the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	`ASSERT_IMPL(a_busy_after_accept, s_tvalid && s_tready, ##1 !s_tready ##1 !s_tready)
	`ASSERT_IMPL(a_result_from_busy, $rose(m_tvalid), !$past(s_tready))

endmodule

bind murmur64_hash_engine mhe_checker u_mhe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/murmur64_hash_checker.sv =====
// ----------------------------------------------------------------------------
// murmur64_hash_checker
// Watches the seed write, input and hash channels of the hash engine. Keeps
// its own copy of the seed and running hash state, predicts each finished hash
// on a last-word transaction and compares it with the next hash delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module murmur64_hash_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [63:0]  cfg_wr_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	output int unsigned  fail_count,
	output int unsigned  hashes_pending,
	output int unsigned  hashes_checked
);

	localparam logic [63:0] MURMUR_M = 64'hc6a4a7935bd1e995;

	typedef struct packed {
		logic [47:0] msg_len;
		logic [63:0] data_word;
		logic        first_word;
		logic        last_word;
	} word_txn_t;

	logic [63:0] seed_reg;
	logic [63:0] hash_acc;
	logic [2:0]  tail_bytes;
	logic        empty_msg;
	logic [63:0] expected_hashes[$];

	function automatic logic [63:0] xorshift47(input logic [63:0] x);
		return x ^ (x >> 47);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: hash check failed: %s", $time, what);
		fail_count++;
	endtask

	// fold one input word into the running hash; a finished hash on the last word
	task automatic absorb_word(input word_txn_t t);
		logic [63:0] keep;
		if (t.first_word) begin
			hash_acc   = seed_reg ^ ({16'h0, t.msg_len} * MURMUR_M);
			tail_bytes = t.msg_len[2:0];
			empty_msg  = (t.msg_len == 48'h0);
		end
		if (!empty_msg) begin
			if (t.last_word && tail_bytes != 3'd0) begin
				keep     = (64'd1 << (8 * tail_bytes)) - 64'd1;
				hash_acc = (hash_acc ^ (t.data_word & keep)) * MURMUR_M;
			end else begin
				hash_acc = (hash_acc ^ (xorshift47(t.data_word * MURMUR_M) * MURMUR_M))
					* MURMUR_M;
			end
		end
		if (t.last_word)
			expected_hashes.push_back(xorshift47(xorshift47(hash_acc) * MURMUR_M));
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_txn_t   t;
		logic [63:0] want;
		if (!arst_n) begin
			seed_reg       = '0;
			hash_acc       = '0;
			tail_bytes     = '0;
			empty_msg      = 1'b0;
			expected_hashes.delete();
			fail_count     = 0;
			hashes_pending = 0;
			hashes_checked = 0;
		end else begin
			if (cfg_wr_en)
				seed_reg = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				if (expected_hashes.size() == 0) begin
					report_mismatch($sformatf("unexpected hash %h", m_tdata));
				end else begin
					want = expected_hashes.pop_front();
					hashes_checked++;
					if (m_tdata !== want)
						report_mismatch($sformatf("hash_value %h, expected %h", m_tdata, want));
				end
			end
			if (s_tvalid && s_tready) begin
				t.msg_len    = s_tdata[111:64];
				t.data_word  = s_tdata[63:0];
				t.first_word = s_tuser;
				t.last_word  = s_tlast;
				absorb_word(t);
			end
			hashes_pending = expected_hashes.size();
		end
	end

endmodule

// ===== verif/murmur64_hash_engine_tb.sv =====
// ----------------------------------------------------------------------------
// murmur64_hash_engine_tb
// Stimulus and verdict for the hash engine. Directed messages cover empty,
// tail, full-word and maximum-length cases and words with no opening word;
// random messages follow under four flow-control phases and several seeds.
// The checker beside the block predicts and compares every hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module murmur64_hash_engine_tb;

	localparam int unsigned RANDOM_PER_PHASE = 430;
	localparam int unsigned SETTLE_CYCLES    = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [63:0]  cfg_wr_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;     // [63:0] data_word, [111:64] message_length
	logic         s_tuser = 1'b0;   // [0] first_word
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;          // [63:0] hash_value

	int unsigned fail_count;
	int unsigned hashes_pending;
	int unsigned hashes_checked;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned words_sent = 0;
	int unsigned messages_sent = 0;

	murmur64_hash_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	murmur64_hash_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.fail_count     (fail_count),
		.hashes_pending (hashes_pending),
		.hashes_checked (hashes_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	initial begin
		#10_000_000;
		$display("timeout waiting for the hash engine");
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [47:0] rand_len48();
		return {16'($urandom), $urandom};
	endfunction

	// one input transaction, held until accepted
	task automatic send_word(input logic [63:0] w, input logic [47:0] len,
			input logic first, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {len, w};
		s_tuser  = first;
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (last)
			messages_sent++;
	endtask

	// n_words transactions; length only meaningful on the opening word
	task automatic send_message(input logic [47:0] msg_len, input int unsigned n_words);
		for (int unsigned i = 0; i < n_words; i++)
			send_word(rand_word(), (i == 0) ? msg_len : rand_len48(), i == 0,
				i == n_words - 1);
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (hashes_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [63:0] value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic random_traffic(input int unsigned n_target);
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		int unsigned extra;
		start = words_sent;
		while (words_sent - start < n_target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = $urandom_range(0, 48);
				send_message(48'(len), (len == 0) ? 1 : (len + 7) / 8);
			end else if (pick < 76) begin
				// huge length, few words
				send_message(rand_len48(), $urandom_range(1, 4));
			end else if (pick < 86) begin
				send_message(48'($urandom_range(0, 40)), $urandom_range(1, 6));
			end else if (pick < 93) begin
				// empty message with ignored words before its end
				extra = $urandom_range(0, 3);
				send_word(rand_word(), 48'h0, 1'b1, extra == 0);
				for (int unsigned i = 0; i < extra; i++)
					send_word(rand_word(), rand_len48(), 1'b0, i == extra - 1);
			end else begin
				// continuation without an opening word
				send_word(rand_word(), rand_len48(), 1'b0, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		logic [63:0]  phase_seed[4];
		int unsigned  phase_idle[4];
		int unsigned  phase_stall[4];

		phase_seed  = '{64'hffff_ffff_ffff_ffff, rand_word(), 64'h0, rand_word()};
		phase_idle  = '{0, 64, 0, 15};
		phase_stall = '{0, 0, 64, 15};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset seed
		send_word(rand_word(), 48'h0, 1'b0, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 48'h0, 1'b1, 1'b1);
		send_word(64'h0123_4567_89ab_cdef, 48'h0, 1'b1, 1'b0);
		send_word(64'hffff_ffff_ffff_ffff, 48'h8, 1'b0, 1'b0);
		send_word(64'hdead_beef_dead_beef, 48'h0, 1'b0, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 48'h8, 1'b1, 1'b1);
		send_word(64'h0, 48'h8, 1'b1, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 48'h7, 1'b1, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 48'h1, 1'b1, 1'b1);
		send_word(64'h8000_0000_0000_0001, 48'hf, 1'b1, 1'b0);
		send_word(64'hffff_ffff_ffff_ffff, 48'h0, 1'b0, 1'b1);
		send_word(64'haaaa_aaaa_aaaa_aaaa, 48'hffff_ffff_ffff, 1'b1, 1'b0);
		send_word(64'h5555_5555_5555_5555, 48'hffff_ffff_ffff, 1'b0, 1'b1);
		send_word(rand_word(), 48'h10, 1'b0, 1'b1);
		send_word(rand_word(), 48'h10, 1'b1, 1'b1);
		send_word(rand_word(), 48'h0, 1'b0, 1'b0);
		send_word(rand_word(), 48'h0, 1'b0, 1'b1);

		for (int p = 0; p < 4; p++) begin
			drain_and_settle();
			write_seed(phase_seed[p]);
			sender_idle_pct    = phase_idle[p];
			receiver_stall_pct = phase_stall[p];
			random_traffic(RANDOM_PER_PHASE);
		end

		drain_and_settle();
		$display("Covered %0d transactions in %0d messages, %0d hashes compared.",
			words_sent, messages_sent, hashes_checked);
		$display("Reset seed plus four written seeds, each under its own idling pattern.");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
